[rtl/pfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int unsigned LetterW = 5;
  localparam int unsigned SqDim   = 5;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned RowW    = LetterW * SqDim;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LetterW-1:0] CodeI   = 5'd8;
  localparam logic [LetterW-1:0] CodeJ   = 5'd9;
  localparam logic [LetterW-1:0] CodeMax = 5'd25;
  localparam logic [IdxW-1:0]    IdxLast = 3'd4;

  // Default square: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ
  localparam logic [RowW-1:0] Row0Rst = 25'd4294688;
  localparam logic [RowW-1:0] Row1Rst = 25'd10755269;
  localparam logic [RowW-1:0] Row2Rst = 25'd16201099;
  localparam logic [RowW-1:0] Row3Rst = 25'd21613104;
  localparam logic [RowW-1:0] Row4Rst = 25'd27025109;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DECRYPT = 3'd0,
    REG_ROW0    = 3'd1,
    REG_ROW1    = 3'd2,
    REG_ROW2    = 3'd3,
    REG_ROW3    = 3'd4,
    REG_ROW4    = 3'd5
  } cfg_reg_e;

  typedef logic [SqDim-1:0][RowW-1:0] square_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } loc_t;

  function automatic logic [LetterW-1:0] sq_entry(input square_t sq,
                                                  input logic [IdxW-1:0] r,
                                                  input logic [IdxW-1:0] c);
    logic [RowW-1:0] word;
    begin
      word = sq[r];
      sq_entry = word[c*LetterW +: LetterW];
    end
  endfunction

  // One step forward or back modulo the square size
  function automatic logic [IdxW-1:0] step_idx(input logic [IdxW-1:0] i,
                                               input logic back);
    begin
      if (back) begin
        step_idx = (i == '0) ? IdxLast : i - 3'd1;
      end else begin
        step_idx = (i == IdxLast) ? '0 : i + 3'd1;
      end
    end
  endfunction

endpackage

`default_nettype wire

[rtl/pfc_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

// Locate one letter in the key square: first match in row-major order.
module pfc_lane (
  input  wire logic [pfc_pkg::LetterW-1:0] letter_i,
  input  wire pfc_pkg::square_t            square_i,
  output pfc_pkg::loc_t                    loc_o
);

  logic [pfc_pkg::LetterW-1:0] code;

  always_comb begin
    code = (letter_i == pfc_pkg::CodeJ) ? pfc_pkg::CodeI : letter_i;
    loc_o = '0;
    // scan backwards so the earliest hit is written last
    for (int r = pfc_pkg::SqDim - 1; r >= 0; r--) begin
      for (int c = pfc_pkg::SqDim - 1; c >= 0; c--) begin
        if (code <= pfc_pkg::CodeMax &&
            pfc_pkg::sq_entry(square_i, r[pfc_pkg::IdxW-1:0],
                              c[pfc_pkg::IdxW-1:0]) == code) begin
          loc_o.found = 1'b1;
          loc_o.row   = r[pfc_pkg::IdxW-1:0];
          loc_o.col   = c[pfc_pkg::IdxW-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pfc_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

// Combine both lane positions into the output pair.
module pfc_merge (
  input  wire pfc_pkg::loc_t               loc_a_i,
  input  wire pfc_pkg::loc_t               loc_b_i,
  input  wire logic [pfc_pkg::LetterW-1:0] letter_a_i,
  input  wire logic [pfc_pkg::LetterW-1:0] letter_b_i,
  input  wire pfc_pkg::square_t            square_i,
  input  wire logic                        back_i,
  output logic [pfc_pkg::LetterW-1:0]      out_a_o,
  output logic [pfc_pkg::LetterW-1:0]      out_b_o,
  output logic                             not_found_o
);

  always_comb begin
    not_found_o = !(loc_a_i.found && loc_b_i.found);
    if (not_found_o) begin
      // pass through raw codes, no folding
      out_a_o = letter_a_i;
      out_b_o = letter_b_i;
    end else if (loc_a_i.row == loc_b_i.row) begin
      out_a_o = pfc_pkg::sq_entry(square_i, loc_a_i.row,
                                  pfc_pkg::step_idx(loc_a_i.col, back_i));
      out_b_o = pfc_pkg::sq_entry(square_i, loc_b_i.row,
                                  pfc_pkg::step_idx(loc_b_i.col, back_i));
    end else if (loc_a_i.col == loc_b_i.col) begin
      out_a_o = pfc_pkg::sq_entry(square_i, pfc_pkg::step_idx(loc_a_i.row, back_i),
                                  loc_a_i.col);
      out_b_o = pfc_pkg::sq_entry(square_i, pfc_pkg::step_idx(loc_b_i.row, back_i),
                                  loc_b_i.col);
    end else begin
      out_a_o = pfc_pkg::sq_entry(square_i, loc_a_i.row, loc_b_i.col);
      out_b_o = pfc_pkg::sq_entry(square_i, loc_b_i.row, loc_a_i.col);
    end
  end

endmodule

`default_nettype wire

[rtl/playfair_digraph_cipher.sv]
`timescale 1ns / 1ps
`default_nettype none

// Playfair digraph transform on a programmable 5x5 key square.
// Pipeline: lookup stage, then merge stage; two lookup lanes and merge, fully pipelined.
// Throughput: one digraph per cycle as long as out_stall_i does not hold the output.
// Reset: asynchronous active low; clears valid flags, sets encrypt mode and the
// default square ABCDE/FGHIK/LMNOP/QRSTU/VWXYZ.
module playfair_digraph_cipher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [pfc_pkg::LetterW-1:0] first_letter_i,
  input  wire logic [pfc_pkg::LetterW-1:0] second_letter_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [pfc_pkg::LetterW-1:0]      out_first_o,
  output logic [pfc_pkg::LetterW-1:0]      out_second_o,
  output logic                             not_found_o,
  // configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [pfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [pfc_pkg::RowW-1:0]    cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are always taken; a write to an index
  // past the register list is dropped.
  // ---------------------------------------------------------------------
  logic             decrypt_q;
  pfc_pkg::square_t square_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q   <= 1'b0;
      square_q[0] <= pfc_pkg::Row0Rst;
      square_q[1] <= pfc_pkg::Row1Rst;
      square_q[2] <= pfc_pkg::Row2Rst;
      square_q[3] <= pfc_pkg::Row3Rst;
      square_q[4] <= pfc_pkg::Row4Rst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pfc_pkg::cfg_reg_e'(cfg_index_i))
        pfc_pkg::REG_DECRYPT: decrypt_q   <= cfg_data_i[0];
        pfc_pkg::REG_ROW0:    square_q[0] <= cfg_data_i;
        pfc_pkg::REG_ROW1:    square_q[1] <= cfg_data_i;
        pfc_pkg::REG_ROW2:    square_q[2] <= cfg_data_i;
        pfc_pkg::REG_ROW3:    square_q[3] <= cfg_data_i;
        pfc_pkg::REG_ROW4:    square_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Each stage advances when it is empty or when the
  // stage after it moves, so a full pipe still takes a beat every cycle
  // as long as the output is drained.
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic out_adv;
  logic s1_adv;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: one lookup lane per letter, each comparing against all 25
  // square cells in parallel.
  // ---------------------------------------------------------------------
  pfc_pkg::loc_t               loc_a_d, loc_b_d;
  pfc_pkg::loc_t               loc_a_q, loc_b_q;
  logic [pfc_pkg::LetterW-1:0] letter_a_q, letter_b_q;

  pfc_lane u_lane_a (
    .letter_i (first_letter_i),
    .square_i (square_q),
    .loc_o    (loc_a_d)
  );

  pfc_lane u_lane_b (
    .letter_i (second_letter_i),
    .square_i (square_q),
    .loc_o    (loc_b_d)
  );

  // Payload holds unless a beat is accepted
  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      loc_a_q    <= loc_a_d;
      loc_b_q    <= loc_b_d;
      letter_a_q <= first_letter_i;
      letter_b_q <= second_letter_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: merge lane results by the row, column or rectangle rule, or pass
  // the raw letters through if either is not found, and register the output beat.
  // ---------------------------------------------------------------------
  logic [pfc_pkg::LetterW-1:0] out_first_d, out_second_d;
  logic                        not_found_d;
  logic [pfc_pkg::LetterW-1:0] out_first_q, out_second_q;
  logic                        not_found_q;

  pfc_merge u_merge (
    .loc_a_i     (loc_a_q),
    .loc_b_i     (loc_b_q),
    .letter_a_i  (letter_a_q),
    .letter_b_i  (letter_b_q),
    .square_i    (square_q),
    .back_i      (decrypt_q),
    .out_a_o     (out_first_d),
    .out_b_o     (out_second_d),
    .not_found_o (not_found_d)
  );

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_first_q  <= out_first_d;
      out_second_q <= out_second_d;
      not_found_q  <= not_found_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;
  assign not_found_o  = not_found_q;

endmodule

`default_nettype wire
